// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, derived widths, character codes and the command and
// status bundles exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 4;
  localparam int CELLS     = COLUMNS * ROWS;

  // Derived widths.
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int COL_SUM_W = $clog2(COLUMNS + TAB_WIDTH);

  // Item function codes.
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Attribute after reset.
  localparam logic [7:0] ATTR_RESET = 8'h07;

  // Register word index of the attribute register.
  localparam logic [0:0] REG_ATTRIBUTE = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // latch the input item and read its cell
    logic exec;        // apply the item to the cursor and screen
    logic out_load;    // load the output register
    logic clear_step;  // write one cell of the reset clearing pass
    logic blank_step;  // write one cell of the scrolled-in row
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scroll;       // the executing item scrolls the screen
    logic sweep_row_end;  // sweep sits on the last column of its row
    logic sweep_all_end;  // sweep sits on the last cell of the screen
    logic out_free;     // output register can take a result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/tcw_ifs.sv =====
// ----------------------------------------------------------------------------
// Text console writer channel interfaces
// Request channel carrying one put or read item, and response channel
// carrying the cursor and the read cell.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] character;
  logic [4:0] read_row;
  logic [6:0] read_column;

  modport source (output valid, func, character, read_row, read_column, input ready);
  modport sink   (input valid, func, character, read_row, read_column, output ready);
endinterface

interface tcw_rsp_if;
  logic        valid;
  logic        ready;
  logic [6:0]  cursor_column;
  logic [4:0]  cursor_row;
  logic [10:0] cursor_location;
  logic [7:0]  read_character;
  logic [7:0]  read_attribute;

  modport source (output valid, cursor_column, cursor_row, cursor_location,
                  read_character, read_attribute, input ready);
  modport sink   (input valid, cursor_column, cursor_row, cursor_location,
                  read_character, read_attribute, output ready);
endinterface

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences the reset clearing pass, item execution, the row blanking
// after a scroll and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire tcw_pkg::dp_status_t status,
  output tcw_pkg::dp_cmd_t         cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_EXEC   = 5'b00100,
    ST_BLANK  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   done;       // result of the current item already loaded
  logic   done_next;

  // State and flag registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    done_next  = done;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.sweep_all_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        done_next = 1'b0;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec     = 1'b1;
        cmd.out_load = status.out_free;
        done_next    = status.out_free;
        if (status.scroll) begin
          state_next = ST_BLANK;
        end else if (status.out_free) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_BLANK: begin
        cmd.blank_step = 1'b1;
        // The result may leave while the new bottom row is blanked.
        if (!done && status.out_free) begin
          cmd.out_load = 1'b1;
          done_next    = 1'b1;
        end
        if (status.sweep_row_end) begin
          if (done || status.out_free) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// Text console writer datapath
// Cursor registers, row-offset ring over the screen memory, the shared
// sweep counter for clearing and blanking, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tcw_pkg::dp_cmd_t    cmd,
  output tcw_pkg::dp_status_t      status,
  input  wire logic [7:0]          attribute,
  input  wire logic                req_func,
  input  wire logic [7:0]          req_character,
  input  wire logic [4:0]          req_read_row,
  input  wire logic [6:0]          req_read_column,
  input  wire logic                rsp_ready,
  output logic                     rsp_valid,
  output logic [6:0]               rsp_cursor_column,
  output logic [4:0]               rsp_cursor_row,
  output logic [10:0]              rsp_cursor_location,
  output logic [7:0]               rsp_read_character,
  output logic [7:0]               rsp_read_attribute
);

  // Maps a screen row to its memory row through the ring offset.
  function automatic logic [tcw_pkg::ROW_W-1:0] phys_row(
    input logic [tcw_pkg::ROW_W-1:0] r,
    input logic [tcw_pkg::ROW_W-1:0] t
  );
    logic [tcw_pkg::ROW_W:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS)) begin
      s = s - (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS);
    end
    return s[tcw_pkg::ROW_W-1:0];
  endfunction

  // Linear memory address of a memory row and column.
  function automatic logic [tcw_pkg::ADDR_W-1:0] cell_addr(
    input logic [tcw_pkg::ROW_W-1:0] r,
    input logic [tcw_pkg::COL_W-1:0] c
  );
    return tcw_pkg::ADDR_W'(r * tcw_pkg::COLUMNS) + tcw_pkg::ADDR_W'(c);
  endfunction

  logic [15:0] mem [tcw_pkg::CELLS];

  logic [tcw_pkg::COL_W-1:0]     col;
  logic [tcw_pkg::ROW_W-1:0]     row;
  logic [tcw_pkg::ROW_W-1:0]     top;
  logic [tcw_pkg::ROW_W-1:0]     sweep_row;
  logic [tcw_pkg::COL_W-1:0]     sweep_col;
  logic                          op_func;
  logic [7:0]                    op_char;
  logic                          op_in_range;
  logic [15:0]                   rd_cell;

  logic [tcw_pkg::COL_W-1:0]     col_next;
  logic [tcw_pkg::ROW_W-1:0]     row_next;
  logic [tcw_pkg::COL_SUM_W-1:0] tab_sum;
  logic [tcw_pkg::COL_SUM_W-1:0] inc_sum;
  logic [tcw_pkg::COL_SUM_W-1:0] adv_sum;
  logic                          advance;
  logic                          new_line;
  logic                          scroll;
  logic                          wr_cell;
  logic                          wr_en;
  logic [tcw_pkg::ROW_W-1:0]     wr_row;
  logic [tcw_pkg::COL_W-1:0]     wr_col;
  logic [15:0]                   wr_data;
  logic [tcw_pkg::ADDR_W-1:0]    wr_addr;
  logic [tcw_pkg::ADDR_W-1:0]    rd_addr;
  logic                          sweep_at_row_end;

  // Candidate columns for a tab and for a printed character.
  assign tab_sum = tcw_pkg::COL_SUM_W'(col)
                 + tcw_pkg::COL_SUM_W'(tcw_pkg::TAB_WIDTH)
                 - tcw_pkg::COL_SUM_W'(col % tcw_pkg::TAB_WIDTH);
  assign inc_sum = tcw_pkg::COL_SUM_W'(col) + tcw_pkg::COL_SUM_W'(1);

  // Cursor movement of a put item.
  always_comb begin
    col_next = col;
    row_next = row;
    adv_sum  = inc_sum;
    advance  = 1'b0;
    new_line = 1'b0;
    scroll   = 1'b0;
    wr_cell  = 1'b0;
    if (cmd.exec && op_func == tcw_pkg::FUNC_PUT) begin
      unique case (op_char)
        tcw_pkg::CH_BACKSPACE: begin
          if (col != '0) begin
            col_next = col - tcw_pkg::COL_W'(1);
          end
        end
        tcw_pkg::CH_TAB: begin
          adv_sum = tab_sum;
          advance = 1'b1;
        end
        tcw_pkg::CH_NEWLINE: begin
          new_line = 1'b1;
        end
        tcw_pkg::CH_RETURN: begin
          col_next = col;
        end
        default: begin
          wr_cell = 1'b1;
          advance = 1'b1;
        end
      endcase
      if (advance) begin
        if (adv_sum >= tcw_pkg::COL_SUM_W'(tcw_pkg::COLUMNS)) begin
          new_line = 1'b1;
        end else begin
          col_next = tcw_pkg::COL_W'(adv_sum);
        end
      end
      if (new_line) begin
        col_next = '0;
        if (row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
          scroll = 1'b1;
        end else begin
          row_next = row + tcw_pkg::ROW_W'(1);
        end
      end
    end
  end

  // Single write port: clearing sweep, blanking sweep or a printed character.
  always_comb begin
    wr_en   = 1'b0;
    wr_row  = phys_row(row, top);
    wr_col  = col;
    wr_data = {attribute, op_char};
    if (cmd.clear_step) begin
      wr_en   = 1'b1;
      wr_row  = sweep_row;
      wr_col  = sweep_col;
      wr_data = {tcw_pkg::ATTR_RESET, tcw_pkg::CH_SPACE};
    end else if (cmd.blank_step) begin
      wr_en   = 1'b1;
      wr_row  = sweep_row;
      wr_col  = sweep_col;
      wr_data = {attribute, tcw_pkg::CH_SPACE};
    end else if (wr_cell) begin
      wr_en = 1'b1;
    end
  end

  assign wr_addr = cell_addr(wr_row, wr_col);
  assign rd_addr = cell_addr(phys_row(tcw_pkg::ROW_W'(req_read_row), top),
                             tcw_pkg::COL_W'(req_read_column));

  // Screen memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.accept) begin
      rd_cell <= mem[rd_addr];
    end
  end

  assign sweep_at_row_end = (sweep_col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));

  // Cursor, ring offset, sweep counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      top       <= '0;
      sweep_row <= '0;
      sweep_col <= '0;
      rsp_valid <= 1'b0;
    end else begin
      col <= col_next;
      row <= row_next;
      if (scroll) begin
        // The old top row comes back as the bottom row and gets blanked.
        sweep_row <= top;
        sweep_col <= '0;
        if (top == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
          top <= '0;
        end else begin
          top <= top + tcw_pkg::ROW_W'(1);
        end
      end else if (cmd.clear_step || cmd.blank_step) begin
        if (sweep_at_row_end) begin
          sweep_col <= '0;
          if (cmd.clear_step) begin
            sweep_row <= sweep_row + tcw_pkg::ROW_W'(1);
          end
        end else begin
          sweep_col <= sweep_col + tcw_pkg::COL_W'(1);
        end
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Item latch at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_func     <= req_func;
      op_char     <= req_character;
      op_in_range <= (req_read_row < 5'(tcw_pkg::ROWS))
                  && (req_read_column < 7'(tcw_pkg::COLUMNS));
    end
  end

  // Output payload, taken from the cursor as it stands after the item.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_cursor_column   <= 7'(col_next);
      rsp_cursor_row      <= 5'(row_next);
      rsp_cursor_location <= 11'(row_next * tcw_pkg::COLUMNS + col_next);
      if (op_func == tcw_pkg::FUNC_READ && op_in_range) begin
        rsp_read_character <= rd_cell[7:0];
        rsp_read_attribute <= rd_cell[15:8];
      end else begin
        rsp_read_character <= '0;
        rsp_read_attribute <= '0;
      end
    end
  end

  assign status.scroll        = scroll;
  assign status.sweep_row_end = sweep_at_row_end;
  assign status.sweep_all_end = sweep_at_row_end
                              && (sweep_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
  assign status.out_free      = !rsp_valid || rsp_ready;

endmodule

`default_nettype wire

// ===== sv/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// Text console writer
// 80x25 character-cell text screen with cursor, put and read items, and an
// APB attribute register.
// ----------------------------------------------------------------------------
// After reset the block writes spaces with attribute 7 into every cell of
// the screen memory and takes no item until that pass ends; the attribute
// register can be written meanwhile. Each put or read item is then accepted,
// which issues the cell read, and executed, which updates the cursor or
// memory and loads the output register, the load waiting until the previous
// result has been taken. A put that moves past the last row scrolls by
// advancing a row offset and then blanks the new bottom row one cell per
// cycle through the single memory write port before the next item is taken.
// Every transaction on the request channel yields exactly one transaction
// on the response channel.
`default_nettype none

module text_console_writer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  tcw_req_if.sink          request,
  tcw_rsp_if.source        response,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  tcw_pkg::dp_cmd_t    cmd;
  tcw_pkg::dp_status_t status;
  logic [7:0]          attribute;
  logic                cfg_write;

  // Attribute register on the APB port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= tcw_pkg::ATTR_RESET;
    end else if (cfg_write && paddr[2:2] == tcw_pkg::REG_ATTRIBUTE) begin
      attribute <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2:2] == tcw_pkg::REG_ATTRIBUTE) ? {24'b0, attribute} : '0;

  // Controller.
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  tcw_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .attribute           (attribute),
    .req_func            (request.func),
    .req_character       (request.character),
    .req_read_row        (request.read_row),
    .req_read_column     (request.read_column),
    .rsp_ready           (response.ready),
    .rsp_valid           (response.valid),
    .rsp_cursor_column   (response.cursor_column),
    .rsp_cursor_row      (response.cursor_row),
    .rsp_cursor_location (response.cursor_location),
    .rsp_read_character  (response.read_character),
    .rsp_read_attribute  (response.read_attribute)
  );

  // An accepted transaction is executed before another can be taken.
  assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> !request.ready)
    else $error("request accepted in back-to-back cycles");

  // A reported cursor always lies on the screen.
  assert property (@(posedge clk) disable iff (rst)
    response.valid |-> (response.cursor_column < 7'(tcw_pkg::COLUMNS))
                    && (response.cursor_row < 5'(tcw_pkg::ROWS)))
    else $error("reported cursor off screen");

  // The linear location matches the reported row and column.
  assert property (@(posedge clk) disable iff (rst)
    response.valid |-> response.cursor_location
      == 11'(response.cursor_row * tcw_pkg::COLUMNS + response.cursor_column))
    else $error("cursor location inconsistent with row and column");

endmodule

`default_nettype wire
